// ----- src/sbrl_pkg.sv -----
`timescale 1ns / 1ps

package sbrl_pkg;

    localparam int SHARD_W = 10;
    localparam int NOW_W = 63;
    localparam int SECS_W = 16;
    localparam int OP_W = 3;
    localparam int WAIT_W = 47;
    localparam int LAST_W = 64;
    localparam int CNT_W = 16;
    localparam int MS_W = 16;
    localparam int PROBE_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 30;
    localparam int ALU_W = 65;
    localparam int RES_W = 66;

    localparam int SHARD_COUNT_DEF = 1024;

    localparam logic [MUL_B_W-1:0] NS_PER_MS = 30'd1000000;
    localparam logic [MUL_B_W-1:0] NS_PER_S = 30'd1000000000;
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [MS_W-1:0] BASE_RESET = 16'd1000;
    localparam logic [MS_W-1:0] STEP_RESET = 16'd500;
    localparam logic [MS_W-1:0] MAX_RESET = 16'd30000;
    localparam logic [PROBE_W-1:0] PROBE_RESET = 32'd50000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE = 2'd0,
        CFG_STEP = 2'd1,
        CFG_MAX = 2'd2,
        CFG_PROBE = 2'd3
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_WAIT = 3'd0,
        OP_FAILURE = 3'd1,
        OP_SUCCESS = 3'd2,
        OP_THROTTLE = 3'd3,
        OP_PROBE = 3'd4,
        OP_RECORD = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_QMUL,
        S_QSUB,
        S_READ,
        S_MUL,
        S_CLAMP,
        S_SCALE,
        S_ADD,
        S_SUB,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [SHARD_W-1:0] shard;
        logic [NOW_W-1:0] now_ns;
        logic [SECS_W-1:0] throttle_seconds;
    } cmd_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_ns;
        logic allowed;
    } result_t;

    typedef struct packed {
        alu_op_t op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic last_we;
        logic cnt_we;
    } mem_ctl_t;

endpackage

// ----- src/sbrl_ram.sv -----
`timescale 1ns / 1ps

module sbrl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sbrl_alu.sv -----
`timescale 1ns / 1ps

module sbrl_alu (
    input  sbrl_pkg::alu_ctl_t              ctl,
    output logic [sbrl_pkg::RES_W-1:0]      res
);

    localparam int RW = sbrl_pkg::RES_W;
    localparam int PW = sbrl_pkg::MUL_A_W + sbrl_pkg::MUL_B_W;

    logic [PW-1:0] prod;

    assign prod = PW'(ctl.a[sbrl_pkg::MUL_A_W-1:0]) * PW'(ctl.b[sbrl_pkg::MUL_B_W-1:0]);

    always_comb
    begin
        case (ctl.op)
            sbrl_pkg::ALU_MUL: res = RW'(prod);
            sbrl_pkg::ALU_ADD: res = RW'(ctl.a) + RW'(ctl.b);
            sbrl_pkg::ALU_SUB: res = RW'(ctl.a) - RW'(ctl.b);
            default:           res = '0;
        endcase
    end

endmodule

// ----- src/sbrl_seq.sv -----
`timescale 1ns / 1ps

module sbrl_seq #(
    parameter int SHARD_COUNT = sbrl_pkg::SHARD_COUNT_DEF,
    parameter int IDX_W = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  sbrl_pkg::cmd_t                   cmd,
    output logic                             busy,
    output logic                             done,
    output sbrl_pkg::result_t                result,
    input  logic [sbrl_pkg::MS_W-1:0]        base_ms,
    input  logic [sbrl_pkg::MS_W-1:0]        step_ms,
    input  logic [sbrl_pkg::MS_W-1:0]        max_ms,
    input  logic [sbrl_pkg::PROBE_W-1:0]     probe_ns,
    output sbrl_pkg::alu_ctl_t               alu_ctl,
    input  logic [sbrl_pkg::RES_W-1:0]       alu_res,
    output sbrl_pkg::mem_ctl_t               mem_ctl,
    output logic [IDX_W-1:0]                 mem_addr,
    output logic [sbrl_pkg::LAST_W-1:0]      last_wdata,
    input  logic [sbrl_pkg::LAST_W-1:0]      last_rdata,
    output logic [sbrl_pkg::CNT_W-1:0]       cnt_wdata,
    input  logic [sbrl_pkg::CNT_W-1:0]       cnt_rdata
);

    localparam int SW = sbrl_pkg::SHARD_W;
    localparam int AW = sbrl_pkg::ALU_W;
    localparam int RW = sbrl_pkg::RES_W;
    localparam int LW = sbrl_pkg::LAST_W;
    localparam int WW = sbrl_pkg::WAIT_W;
    localparam bit NEED_RED = SHARD_COUNT < (1 << SW);
    localparam int RED_SH = 2 * SW;
    localparam logic [AW-1:0] RECIP = AW'(((1 << RED_SH) + SHARD_COUNT - 1) / SHARD_COUNT);
    localparam int XW = (IDX_W > SW) ? IDX_W : SW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SHARD_COUNT - 1);

    sbrl_pkg::state_t state_reg, state_next;
    logic done_reg, done_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [SW-1:0] red_reg, red_next;
    logic [sbrl_pkg::OP_W-1:0] op_reg, op_next;
    logic [sbrl_pkg::NOW_W-1:0] now_reg, now_next;
    logic [sbrl_pkg::SECS_W-1:0] secs_reg, secs_next;
    logic [RW-1:0] acc_reg, acc_next;
    logic [RW-1:0] diff_reg, diff_next;
    sbrl_pkg::result_t result_reg, result_next;

    logic [XW-1:0] idx_ext;
    logic [31:0] extra_lim;

    assign idx_ext = XW'(red_reg);
    assign extra_lim = (acc_reg[31:0] > 32'(max_ms)) ? 32'(max_ms) : acc_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbrl_pkg::S_CLEAR;
            done_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg <= red_next;
        op_reg <= op_next;
        now_reg <= now_next;
        secs_reg <= secs_next;
        acc_reg <= acc_next;
        diff_reg <= diff_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        clr_next = clr_reg;
        red_next = red_reg;
        op_next = op_reg;
        now_next = now_reg;
        secs_next = secs_reg;
        acc_next = acc_reg;
        diff_next = diff_reg;
        result_next = result_reg;
        alu_ctl = '{op: sbrl_pkg::ALU_ADD, a: '0, b: '0};
        mem_ctl = '0;
        mem_addr = idx_ext[IDX_W-1:0];
        last_wdata = '0;
        cnt_wdata = '0;

        unique case (state_reg)
            sbrl_pkg::S_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_ctl.last_we = 1'b1;
                mem_ctl.cnt_we = 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = sbrl_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            sbrl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next = cmd.operation;
                    red_next = cmd.shard;
                    now_next = cmd.now_ns;
                    secs_next = cmd.throttle_seconds;
                    state_next = NEED_RED ? sbrl_pkg::S_REDUCE : sbrl_pkg::S_READ;
                end
            end
            sbrl_pkg::S_REDUCE:
            begin
                alu_ctl.op = sbrl_pkg::ALU_MUL;
                alu_ctl.a = AW'(red_reg);
                alu_ctl.b = RECIP;
                acc_next = alu_res;
                state_next = sbrl_pkg::S_QMUL;
            end
            sbrl_pkg::S_QMUL:
            begin
                alu_ctl.op = sbrl_pkg::ALU_MUL;
                alu_ctl.a = AW'(acc_reg[RED_SH+SW-1:RED_SH]);
                alu_ctl.b = AW'(SHARD_COUNT);
                acc_next = alu_res;
                state_next = sbrl_pkg::S_QSUB;
            end
            sbrl_pkg::S_QSUB:
            begin
                alu_ctl.op = sbrl_pkg::ALU_SUB;
                alu_ctl.a = AW'(red_reg);
                alu_ctl.b = acc_reg[AW-1:0];
                red_next = alu_res[SW-1:0];
                state_next = sbrl_pkg::S_READ;
            end
            sbrl_pkg::S_READ:
            begin
                mem_ctl.rd_en = 1'b1;
                case (op_reg)
                    sbrl_pkg::OP_WAIT,
                    sbrl_pkg::OP_THROTTLE: state_next = sbrl_pkg::S_MUL;
                    sbrl_pkg::OP_PROBE:    state_next = sbrl_pkg::S_ADD;
                    default:               state_next = sbrl_pkg::S_FIN;
                endcase
            end
            sbrl_pkg::S_MUL:
            begin
                alu_ctl.op = sbrl_pkg::ALU_MUL;
                if (op_reg == sbrl_pkg::OP_WAIT)
                begin
                    alu_ctl.a = AW'(cnt_rdata);
                    alu_ctl.b = AW'(step_ms);
                    state_next = sbrl_pkg::S_CLAMP;
                end
                else
                begin
                    alu_ctl.a = AW'(secs_reg);
                    alu_ctl.b = AW'(sbrl_pkg::NS_PER_S);
                    state_next = sbrl_pkg::S_ADD;
                end
                acc_next = alu_res;
            end
            sbrl_pkg::S_CLAMP:
            begin
                alu_ctl.op = sbrl_pkg::ALU_ADD;
                alu_ctl.a = AW'(extra_lim);
                alu_ctl.b = AW'(base_ms);
                acc_next = alu_res;
                state_next = sbrl_pkg::S_SCALE;
            end
            sbrl_pkg::S_SCALE:
            begin
                alu_ctl.op = sbrl_pkg::ALU_MUL;
                alu_ctl.a = acc_reg[AW-1:0];
                alu_ctl.b = AW'(sbrl_pkg::NS_PER_MS);
                acc_next = alu_res;
                state_next = sbrl_pkg::S_ADD;
            end
            sbrl_pkg::S_ADD:
            begin
                alu_ctl.op = sbrl_pkg::ALU_ADD;
                case (op_reg)
                    sbrl_pkg::OP_THROTTLE:
                    begin
                        alu_ctl.a = AW'(now_reg);
                        alu_ctl.b = acc_reg[AW-1:0];
                        state_next = sbrl_pkg::S_FIN;
                    end
                    sbrl_pkg::OP_PROBE:
                    begin
                        alu_ctl.a = AW'(last_rdata);
                        alu_ctl.b = AW'(probe_ns);
                        state_next = sbrl_pkg::S_SUB;
                    end
                    default:
                    begin
                        alu_ctl.a = AW'(last_rdata);
                        alu_ctl.b = acc_reg[AW-1:0];
                        state_next = sbrl_pkg::S_SUB;
                    end
                endcase
                acc_next = alu_res;
            end
            sbrl_pkg::S_SUB:
            begin
                alu_ctl.op = sbrl_pkg::ALU_SUB;
                alu_ctl.a = acc_reg[AW-1:0];
                alu_ctl.b = AW'(now_reg);
                diff_next = alu_res;
                state_next = sbrl_pkg::S_FIN;
            end
            sbrl_pkg::S_FIN:
            begin
                done_next = 1'b1;
                state_next = sbrl_pkg::S_IDLE;
                result_next = '0;
                case (op_reg)
                    sbrl_pkg::OP_WAIT:
                    begin
                        mem_ctl.last_we = 1'b1;
                        if (diff_reg[RW-1] || diff_reg == '0)
                        begin
                            last_wdata = LW'(now_reg);
                        end
                        else
                        begin
                            last_wdata = acc_reg[LW] ? {LW{1'b1}} : acc_reg[LW-1:0];
                            result_next.wait_ns = (|diff_reg[RW-2:WW]) ?
                                sbrl_pkg::WAIT_MAX : diff_reg[WW-1:0];
                        end
                    end
                    sbrl_pkg::OP_FAILURE:
                    begin
                        mem_ctl.cnt_we = 1'b1;
                        cnt_wdata = (cnt_rdata == sbrl_pkg::CNT_MAX) ?
                            cnt_rdata : cnt_rdata + 1'b1;
                    end
                    sbrl_pkg::OP_SUCCESS:
                    begin
                        mem_ctl.cnt_we = 1'b1;
                    end
                    sbrl_pkg::OP_THROTTLE:
                    begin
                        mem_ctl.last_we = 1'b1;
                        last_wdata = acc_reg[LW-1:0];
                    end
                    sbrl_pkg::OP_PROBE:
                    begin
                        result_next.allowed = diff_reg[RW-1];
                    end
                    sbrl_pkg::OP_RECORD:
                    begin
                        mem_ctl.last_we = 1'b1;
                        last_wdata = LW'(now_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = sbrl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != sbrl_pkg::S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

endmodule

// ----- src/shard_backoff_rate_limiter.sv -----
`timescale 1ns / 1ps

// Per-shard rate limiter with linear backoff. A command transaction is taken
// when start is high and busy is low; it carries the operation, the shard, the
// current time and a throttle duration. Exactly one result transaction follows
// for every command: done is high for one cycle with wait_ns and allowed on the
// result port. The receiver cannot hold results off, and none is needed since
// a new command is only taken once busy drops, in the same cycle as done.
// Every command runs on one shared multiply/add/subtract unit under a
// sequencer. A wait passes read, multiply, clamp, scale, add, subtract and
// finish; throttle read, multiply, add and finish; can-request read, add,
// subtract and finish; the others read and finish. With SHARD_COUNT below
// 1024, reduce, quotient-multiply and quotient-subtract come first and reduce
// the shard index modulo SHARD_COUNT by a reciprocal multiplication. The two
// per-shard tables are single-port memories. After reset, a clearing pass
// writes zero to every shard entry, one entry a cycle, with busy high; config
// writes are taken at any time and registers return to reset values at reset.

module shard_backoff_rate_limiter #(
    parameter int SHARD_COUNT = sbrl_pkg::SHARD_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sbrl_pkg::cmd_t                    cmd,
    output logic                              done,
    output sbrl_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [sbrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbrl_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
    localparam int MW = sbrl_pkg::MS_W;

    logic [MW-1:0] base_reg, step_reg, max_reg;
    logic [sbrl_pkg::PROBE_W-1:0] probe_reg;

    sbrl_pkg::alu_ctl_t alu_ctl;
    logic [sbrl_pkg::RES_W-1:0] alu_res;
    sbrl_pkg::mem_ctl_t mem_ctl;
    logic [IDX_W-1:0] mem_addr;
    logic [sbrl_pkg::LAST_W-1:0] last_wdata, last_rdata;
    logic [sbrl_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= sbrl_pkg::BASE_RESET;
            step_reg <= sbrl_pkg::STEP_RESET;
            max_reg <= sbrl_pkg::MAX_RESET;
            probe_reg <= sbrl_pkg::PROBE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbrl_pkg::CFG_BASE:  base_reg <= cfg_data[MW-1:0];
                sbrl_pkg::CFG_STEP:  step_reg <= cfg_data[MW-1:0];
                sbrl_pkg::CFG_MAX:   max_reg <= cfg_data[MW-1:0];
                sbrl_pkg::CFG_PROBE: probe_reg <= cfg_data[sbrl_pkg::PROBE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sbrl_seq #(
        .SHARD_COUNT (SHARD_COUNT),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .base_ms    (base_reg),
        .step_ms    (step_reg),
        .max_ms     (max_reg),
        .probe_ns   (probe_reg),
        .alu_ctl    (alu_ctl),
        .alu_res    (alu_res),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .last_wdata (last_wdata),
        .last_rdata (last_rdata),
        .cnt_wdata  (cnt_wdata),
        .cnt_rdata  (cnt_rdata)
    );

    sbrl_alu u_alu (
        .ctl (alu_ctl),
        .res (alu_res)
    );

    sbrl_ram #(
        .WIDTH  (sbrl_pkg::LAST_W),
        .DEPTH  (SHARD_COUNT),
        .ADDR_W (IDX_W)
    ) u_last_ram (
        .clk   (clk),
        .we    (mem_ctl.last_we),
        .rd_en (mem_ctl.rd_en),
        .addr  (mem_addr),
        .wdata (last_wdata),
        .rdata (last_rdata)
    );

    sbrl_ram #(
        .WIDTH  (sbrl_pkg::CNT_W),
        .DEPTH  (SHARD_COUNT),
        .ADDR_W (IDX_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (mem_ctl.cnt_we),
        .rd_en (mem_ctl.rd_en),
        .addr  (mem_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

endmodule

// ----- tb/sv/sbrl_checker.sv -----
`timescale 1ns / 1ps

module sbrl_checker
    import sbrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   failures,
    output int                   pending
);

    logic [MS_W-1:0]    base_ms;
    logic [MS_W-1:0]    step_ms;
    logic [MS_W-1:0]    cap_ms;
    logic [PROBE_W-1:0] probe_ns;

    logic [LAST_W-1:0] last_seen [SHARD_COUNT_DEF];
    logic [CNT_W-1:0]  fail_tally [SHARD_COUNT_DEF];
    result_t           owed_results [$];

    function automatic logic [LAST_W-1:0] sat_add(input logic [LAST_W-1:0] a,
                                                  input logic [LAST_W-1:0] b);
        logic [LAST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LAST_W] ? {LAST_W{1'b1}} : sum[LAST_W-1:0];
    endfunction

    function automatic result_t shard_outcome(input cmd_t c);
        int unsigned       idx;
        logic [LAST_W-1:0] now;
        logic [LAST_W-1:0] last;
        logic [LAST_W-1:0] delay;
        logic [LAST_W-1:0] owed;
        logic [31:0]       extra;
        result_t           r;
        idx = c.shard % SHARD_COUNT_DEF;
        now = {1'b0, c.now_ns};
        last = last_seen[idx];
        r = '0;
        case (c.operation)
            OP_WAIT:
            begin
                extra = 32'(fail_tally[idx]) * 32'(step_ms);
                if (extra > 32'(cap_ms))
                    extra = 32'(cap_ms);
                delay = (64'(base_ms) + 64'(extra)) * 64'(NS_PER_MS);
                if (now >= last && now - last >= delay)
                    last_seen[idx] = now;
                else
                begin
                    owed = (now >= last) ? delay - (now - last)
                                         : sat_add(last - now, delay);
                    r.wait_ns = (owed > 64'(WAIT_MAX)) ? WAIT_MAX : owed[WAIT_W-1:0];
                    last_seen[idx] = sat_add(last, delay);
                end
            end
            OP_FAILURE:
            begin
                if (fail_tally[idx] != CNT_MAX)
                    fail_tally[idx] = fail_tally[idx] + 1'b1;
            end
            OP_SUCCESS:
                fail_tally[idx] = '0;
            OP_THROTTLE:
                last_seen[idx] = now + 64'(c.throttle_seconds) * 64'(NS_PER_S);
            OP_PROBE:
                r.allowed = (now >= last) && (now - last > 64'(probe_ns));
            OP_RECORD:
                last_seen[idx] = now;
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ms = BASE_RESET;
            step_ms = STEP_RESET;
            cap_ms = MAX_RESET;
            probe_ns = PROBE_RESET;
            for (int i = 0; i < SHARD_COUNT_DEF; i++)
            begin
                last_seen[i] = '0;
                fail_tally[i] = '0;
            end
            owed_results.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE:  base_ms = cfg_data[MS_W-1:0];
                    CFG_STEP:  step_ms = cfg_data[MS_W-1:0];
                    CFG_MAX:   cap_ms = cfg_data[MS_W-1:0];
                    CFG_PROBE: probe_ns = cfg_data[PROBE_W-1:0];
                    default:   ;
                endcase
            end
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("Result transaction with no outstanding command: %s %0d %s %0d",
                           "wait_ns", result.wait_ns, "allowed", result.allowed);
                    failures++;
                end
                else
                begin
                    result_t want;
                    want = owed_results.pop_front();
                    if (result.wait_ns !== want.wait_ns)
                    begin
                        $error("wait_ns mismatch: expected %0d, actual %0d",
                               want.wait_ns, result.wait_ns);
                        failures++;
                    end
                    if (result.allowed !== want.allowed)
                    begin
                        $error("allowed mismatch: expected %0d, actual %0d",
                               want.allowed, result.allowed);
                        failures++;
                    end
                end
            end
            if (start && !busy)
                owed_results.push_back(shard_outcome(cmd));
            pending = owed_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_shard_backoff_rate_limiter.sv -----
`timescale 1ns / 1ps

module tb_shard_backoff_rate_limiter;

    import sbrl_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam logic [NOW_W-1:0] NOW_TOP = {NOW_W{1'b1}};
    localparam logic [SECS_W-1:0] SECS_TOP = {SECS_W{1'b1}};
    localparam logic [NOW_W-1:0] SEC = 63'd1000000000;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 240;
    localparam int CALM_ITEMS = 150;
    localparam int FAIL_BURST = 70;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int                   failures;
    int                   pending;
    int unsigned          cycles;
    logic [NOW_W-1:0]     wall_ns;
    logic [SHARD_W-1:0]   hot_base;

    shard_backoff_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sbrl_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("shard_backoff_rate_limiter test failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SHARD_W-1:0] shard,
                            input logic [NOW_W-1:0] now, input logic [SECS_W-1:0] secs);
        cmd_t c;
        c.operation = op;
        c.shard = shard;
        c.now_ns = now;
        c.throttle_seconds = secs;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic maybe_pause(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic load_limits(input logic [MS_W-1:0] base, input logic [MS_W-1:0] step,
                               input logic [MS_W-1:0] cap, input logic [PROBE_W-1:0] probe);
        settle();
        write_reg(CFG_BASE, CFG_W'(base));
        write_reg(CFG_STEP, CFG_W'(step));
        write_reg(CFG_MAX, CFG_W'(cap));
        write_reg(CFG_PROBE, probe);
        cfg_we <= 1'b0;
        hot_base = SHARD_W'($urandom_range(0, 1016));
    endtask

    task automatic random_cmd(input bit allow_pause);
        logic [OP_W-1:0]    op;
        logic [SHARD_W-1:0] shard;
        logic [NOW_W-1:0]   now;
        logic [SECS_W-1:0]  secs;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_WAIT;
        else if (pick < 50)
            op = OP_FAILURE;
        else if (pick < 58)
            op = OP_SUCCESS;
        else if (pick < 63)
            op = OP_THROTTLE;
        else if (pick < 80)
            op = OP_PROBE;
        else if (pick < 95)
            op = OP_RECORD;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        if ($urandom_range(0, 99) < 85)
            shard = hot_base + SHARD_W'($urandom_range(0, 7));
        else
            shard = SHARD_W'($urandom);
        if ($urandom_range(0, 1))
            wall_ns = wall_ns + NOW_W'($urandom_range(0, 1500)) * 63'd1000000;
        else
            wall_ns = wall_ns + NOW_W'($urandom_range(0, 100000000));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            now = NOW_W'({$urandom, $urandom});
        else if (pick < 12)
            now = wall_ns - NOW_W'($urandom_range(0, 500000000));
        else
            now = wall_ns;
        if ($urandom_range(0, 4) == 0)
            secs = SECS_W'($urandom);
        else
            secs = SECS_W'($urandom_range(0, 3));
        send_cmd(op, shard, now, secs);
        maybe_pause(allow_pause);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = '0;
        cycles = 0;
        wall_ns = 63'd5000000000 + NOW_W'($urandom);
        hot_base = SHARD_W'($urandom_range(0, 1016));
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cmd(OP_PROBE, 10'd0, 63'd0, 16'd0);
        send_cmd(OP_WAIT, 10'd0, 63'd0, 16'd0);
        send_cmd(OP_WAIT, 10'd0, 63'd0, 16'd0);
        send_cmd(OP_WAIT, 10'd0, 3 * SEC, 16'd0);
        maybe_pause(1'b1);
        send_cmd(OP_WAIT, 10'd0, 4 * SEC - 1, 16'd0);
        send_cmd(OP_RECORD, 10'd1, 10 * SEC, 16'd0);
        send_cmd(OP_PROBE, 10'd1, 10 * SEC + 63'd50000000, 16'd0);
        send_cmd(OP_PROBE, 10'd1, 10 * SEC + 63'd50000001, 16'd0);
        repeat (3) send_cmd(OP_FAILURE, 10'd1, 11 * SEC, 16'd0);
        send_cmd(OP_WAIT, 10'd1, 20 * SEC, 16'd0);
        send_cmd(OP_WAIT, 10'd1, 20 * SEC, 16'd0);
        send_cmd(OP_SUCCESS, 10'd1, 20 * SEC, 16'd0);
        send_cmd(OP_WAIT, 10'd1, 20 * SEC, 16'd0);
        maybe_pause(1'b1);
        send_cmd(OP_THROTTLE, 10'd2, 100 * SEC, SECS_TOP);
        send_cmd(OP_PROBE, 10'd2, 100 * SEC, 16'd0);
        send_cmd(OP_WAIT, 10'd2, 100 * SEC, 16'd0);
        send_cmd(OP_RECORD, 10'd1023, NOW_TOP, 16'd0);
        send_cmd(OP_WAIT, 10'd1023, 63'd0, 16'd0);
        send_cmd(OP_PROBE, 10'd1023, 63'd0, 16'd0);
        send_cmd(OP_THROTTLE, 10'd1022, NOW_TOP, SECS_TOP);
        send_cmd(OP_WAIT, 10'd1022, NOW_TOP, 16'd0);
        send_cmd(OP_PROBE, 10'd1022, NOW_TOP, 16'd0);
        send_cmd(OP_SPARE_A, 10'd0, NOW_TOP, SECS_TOP);
        send_cmd(OP_SPARE_B, 10'd0, 63'd0, SECS_TOP);

        for (int i = 0; i < FAIL_BURST; i++)
            send_cmd(OP_FAILURE, 10'd512, 63'd0, 16'd0);
        send_cmd(OP_WAIT, 10'd512, 63'd0, 16'd0);
        send_cmd(OP_SUCCESS, 10'd512, 63'd0, 16'd0);
        send_cmd(OP_WAIT, 10'd512, 63'd0, 16'd0);

        repeat (PHASE_ITEMS) random_cmd(1'b1);

        load_limits('0, '0, '0, '0);
        repeat (PHASE_ITEMS) random_cmd(1'b1);

        load_limits({MS_W{1'b1}}, {MS_W{1'b1}}, {MS_W{1'b1}}, {PROBE_W{1'b1}});
        repeat (PHASE_ITEMS) random_cmd(1'b1);

        load_limits(MS_W'($urandom), MS_W'($urandom), MS_W'($urandom), $urandom);
        repeat (PHASE_ITEMS) random_cmd(1'b1);

        load_limits(MS_W'($urandom_range(0, 200)), MS_W'($urandom_range(0, 100)),
                    MS_W'($urandom_range(0, 2000)), $urandom_range(0, 1000000000));
        repeat (PHASE_ITEMS - CALM_ITEMS) random_cmd(1'b1);
        repeat (CALM_ITEMS) random_cmd(1'b0);

        settle();
        repeat (20) @(negedge clk);
        if (failures == 0)
            $display("shard_backoff_rate_limiter test passed");
        else
            $display("shard_backoff_rate_limiter test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/sbrl_pkg.sv
src/sbrl_ram.sv
src/sbrl_alu.sv
src/sbrl_seq.sv
src/shard_backoff_rate_limiter.sv
tb/sv/sbrl_checker.sv
tb/sv/tb_shard_backoff_rate_limiter.sv
